/* sv/lrua_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU aging replacement package
// Shared widths, codes and reset values for the timestamp replacement block.
// ----------------------------------------------------------------------------
package lrua_pkg;

   localparam int STAMP_W = 32;
   localparam int KIND_W  = 2;
   localparam int SETF_W  = 10;
   localparam int WAYF_W  = 4;

   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [KIND_W-1:0]  kind_type;

   // Word kinds carried in tuser.
   localparam kind_type KIND_QUERY  = 2'd0;
   localparam kind_type KIND_FILL   = 2'd1;
   localparam kind_type KIND_UPDATE = 2'd2;

   // Register index as decoded from the CSR address (paddr[2]).
   localparam logic CSR_AGING_INTERVAL = 1'b0;
   localparam logic CSR_AGING_AMOUNT   = 1'b1;

   localparam stamp_type AGING_RESET = 32'd1000;
   localparam stamp_type STAMP_MAX   = '1;

endpackage

/* sv/lru_aging_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU aging replacement
// Timestamp based victim selection for a set-associative cache, with
// periodic aging of all stamps held in a row-per-set stamp memory.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_*   | in        | tuser: kind; tdata: set_index, way, hit, is_write
//  rsp_*   | out       | tdata: victim_way
//  csr_*   | in/out    | aging_interval at 0x0, aging_amount at 0x4
//
//  Fills and access updates write the way's stamp directly into the
//  stamp memory at the edge that accepts the word.
//  A victim query reads the set row from the stamp memory, loads it into
//  the halving minimum tree and reduces it one level at a time to the victim.
//  When aging is due, a query first sweeps the stamp memory one row a cycle,
//  read and write overlapped, before the set row is read.
//  After reset a clearing pass zeroes the memory row by row; req_tready
//  stays low meanwhile, CSR writes are taken as usual.
//  A finished result waits in the output register without blocking new words.
// ----------------------------------------------------------------------------
module lru_aging_replacement
   import lrua_pkg::*;
#(
   parameter int SETS = 1024,
   parameter int WAYS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] set_index, [13:10] way, [14] hit, [15] is_write
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] victim_way, [7:4] zero
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int PTR_W = SET_W + 1;
   localparam int WAY_W = $clog2(WAYS);
   localparam int P2    = 1 << WAY_W;
   localparam int LVL_W = $clog2(WAY_W + 1);

   localparam logic [PTR_W-1:0] ROW_LAST = PTR_W'(SETS - 1);
   localparam logic [PTR_W-1:0] ROW_END  = PTR_W'(SETS);
   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(WAY_W - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_MIN   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   typedef logic [WAYS-1:0][STAMP_W-1:0] row_type;

   // stamp memory
   row_type     stamp_mem [SETS];
   row_type     rd_row_ff;
   logic        mem_re;
   logic [SET_W-1:0] mem_ra;
   logic        mem_row_we;
   logic        mem_way_we;
   logic [SET_W-1:0] mem_wa;
   logic [WAY_W-1:0] mem_ww;
   row_type     mem_wrow;
   stamp_type   mem_wstamp;

   // control and datapath registers
   logic [2:0]       state_ff,    state_in;
   stamp_type        cnt_ff,      cnt_in;
   stamp_type        last_age_ff, last_age_in;
   stamp_type        interval_ff, interval_in;
   stamp_type        amount_ff,   amount_in;
   logic [PTR_W-1:0] row_ptr_ff,  row_ptr_in;
   logic             wr_pend_ff,  wr_pend_in;
   logic [SET_W-1:0] wr_row_ff,   wr_row_in;
   logic [SET_W-1:0] qset_ff,     qset_in;
   logic             qoor_ff,     qoor_in;
   logic [LVL_W-1:0] lvl_ff,      lvl_in;
   stamp_type        tree_val_ff [P2];
   stamp_type        tree_val_in [P2];
   logic [WAY_W-1:0] tree_idx_ff [P2];
   logic [WAY_W-1:0] tree_idx_in [P2];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_way_ff,   rsp_way_in;

   // request decode
   kind_type         req_kind;
   logic [SETF_W-1:0] req_set;
   logic [WAYF_W-1:0] req_way;
   logic             req_hit;
   logic             req_is_write;
   logic             req_accept;
   logic             set_ok;
   logic             way_ok;
   logic             age_due;
   logic             csr_write;
   row_type          aged_row;

   assign req_kind     = req_tuser;
   assign req_set      = req_tdata[9:0];
   assign req_way      = req_tdata[13:10];
   assign req_hit      = req_tdata[14];
   assign req_is_write = req_tdata[15];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign set_ok     = 32'(req_set) < 32'(SETS);
   assign way_ok     = 32'(req_way) < 32'(WAYS);
   assign age_due    = (cnt_ff - last_age_ff) >= interval_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_way_ff};

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         CSR_AGING_INTERVAL: csr_prdata = interval_ff;
         CSR_AGING_AMOUNT:   csr_prdata = amount_ff;
      endcase
   end

   // Each stamp of the row just read, lowered by the aging amount and floored at zero.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         aged_row[w] = (rd_row_ff[w] > amount_ff) ? (rd_row_ff[w] - amount_ff) : '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_age_in  = last_age_ff;
      interval_in  = interval_ff;
      amount_in    = amount_ff;
      row_ptr_in   = row_ptr_ff;
      wr_pend_in   = wr_pend_ff;
      wr_row_in    = wr_row_ff;
      qset_in      = qset_ff;
      qoor_in      = qoor_ff;
      lvl_in       = lvl_ff;
      tree_val_in  = tree_val_ff;
      tree_idx_in  = tree_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_way_in   = rsp_way_ff;
      mem_re       = 1'b0;
      mem_ra       = '0;
      mem_row_we   = 1'b0;
      mem_way_we   = 1'b0;
      mem_wa       = '0;
      mem_ww       = WAY_W'(req_way);
      mem_wrow     = aged_row;
      mem_wstamp   = cnt_ff;

      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_AGING_INTERVAL: interval_in = csr_pwdata;
            CSR_AGING_AMOUNT:   amount_in   = csr_pwdata;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_row_we = 1'b1;
            mem_wa     = row_ptr_ff[SET_W-1:0];
            mem_wrow   = '0;
            if (row_ptr_ff == ROW_LAST) begin
               row_ptr_in = '0;
               state_in   = ST_IDLE;
            end else begin
               row_ptr_in = row_ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_FILL ||
                   (req_kind == KIND_UPDATE && req_hit && !req_is_write)) begin
                  if (set_ok && way_ok) begin
                     mem_way_we = 1'b1;
                     mem_wa     = SET_W'(req_set);
                     if (cnt_ff != STAMP_MAX) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end else if (req_kind == KIND_QUERY) begin
                  qset_in = SET_W'(req_set);
                  qoor_in = !set_ok;
                  if (age_due) begin
                     row_ptr_in = '0;
                     wr_pend_in = 1'b0;
                     state_in   = ST_SWEEP;
                  end else begin
                     mem_re   = set_ok;
                     mem_ra   = SET_W'(req_set);
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_SWEEP: begin
            // Row r is read while row r-1, read in the cycle before, is written back aged.
            if (wr_pend_ff) begin
               mem_row_we = 1'b1;
               mem_wa     = wr_row_ff;
               mem_wrow   = aged_row;
            end
            if (row_ptr_ff != ROW_END) begin
               mem_re     = 1'b1;
               mem_ra     = row_ptr_ff[SET_W-1:0];
               wr_row_in  = row_ptr_ff[SET_W-1:0];
               wr_pend_in = 1'b1;
               row_ptr_in = row_ptr_ff + 1'b1;
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  last_age_in = cnt_ff;
                  mem_re      = !qoor_ff;
                  mem_ra      = qset_ff;
                  state_in    = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // Ways beyond WAYS are padded with the largest stamp; ties keep the lower way.
            for (int i = 0; i < P2; i++) begin
               if (i < WAYS) begin
                  tree_val_in[i] = rd_row_ff[i];
               end else begin
                  tree_val_in[i] = STAMP_MAX;
               end
               tree_idx_in[i] = WAY_W'(i);
            end
            lvl_in   = '0;
            state_in = ST_MIN;
         end
         ST_MIN: begin
            for (int i = 0; i < P2 / 2; i++) begin
               if (tree_val_ff[2*i+1] < tree_val_ff[2*i]) begin
                  tree_val_in[i] = tree_val_ff[2*i+1];
                  tree_idx_in[i] = tree_idx_ff[2*i+1];
               end else begin
                  tree_val_in[i] = tree_val_ff[2*i];
                  tree_idx_in[i] = tree_idx_ff[2*i];
               end
            end
            lvl_in = lvl_ff + 1'b1;
            if (lvl_ff == LVL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_way_in   = qoor_ff ? 4'd0 : 4'(tree_idx_ff[0]);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         last_age_ff  <= '0;
         interval_ff  <= AGING_RESET;
         amount_ff    <= AGING_RESET;
         row_ptr_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_age_ff  <= last_age_in;
         interval_ff  <= interval_in;
         amount_ff    <= amount_in;
         row_ptr_ff   <= row_ptr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_row_ff   <= wr_row_in;
      qset_ff     <= qset_in;
      qoor_ff     <= qoor_in;
      lvl_ff      <= lvl_in;
      tree_val_ff <= tree_val_in;
      tree_idx_ff <= tree_idx_in;
      rsp_way_ff  <= rsp_way_in;
   end

   // Stamp memory: one write port (whole row or single way), one registered read port.
   always_ff @(posedge clock) begin
      if (mem_row_we) begin
         stamp_mem[mem_wa] <= mem_wrow;
      end else if (mem_way_we) begin
         stamp_mem[mem_wa][mem_ww] <= mem_wstamp;
      end
      if (mem_re) begin
         rd_row_ff <= stamp_mem[mem_ra];
      end
   end

   a_no_rw_same_row: assert property (@(posedge clock) disable iff (reset)
      (mem_re && (mem_row_we || mem_way_we)) |-> (mem_ra != mem_wa))
      else $error("stamp memory read and write hit the same row");

   a_counter_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cnt_ff >= $past(cnt_ff)))
      else $error("access counter moved backward");

   a_aging_point_bound: assert property (@(posedge clock) disable iff (reset)
      last_age_ff <= cnt_ff)
      else $error("last aging point ahead of the access counter");

   a_result_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response word without a finished victim query");

endmodule
